/* rtl/afdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package afdc_pkg;

  localparam int unsigned DIST_W = 32;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned MULB_W = COEF_W + 1;
  localparam int unsigned PROD_W = DIST_W + MULB_W;
  localparam int unsigned PC_W   = 4;

  localparam logic [COEF_W-1:0] GAIN_RST     = 16'd13844;
  localparam logic [COEF_W-1:0] DEADBAND_RST = 16'd6554;
  localparam logic [COEF_W-1:0] SETTLE_RST   = 16'd1311;
  localparam logic [COEF_W-1:0] ZOOM_OUT_RST = 16'd13107;
  localparam logic [COEF_W-1:0] ZOOM_IN_RST  = 16'd3277;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_GAIN     = 3'd1,
    REG_DEADBAND = 3'd2,
    REG_SETTLE   = 3'd3,
    REG_ZOOM_OUT = 3'd4,
    REG_ZOOM_IN  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              enable;
    logic [COEF_W-1:0] gain;
    logic [COEF_W-1:0] deadband;
    logic [COEF_W-1:0] settle;
    logic [COEF_W-1:0] zoom_out;
    logic [COEF_W-1:0] zoom_in;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_GAIN,
    OP_TARGET,
    OP_MUL_DEAD,
    OP_CMP_DEAD,
    OP_MUL_SETTLE,
    OP_HYST,
    OP_MUL_RATE,
    OP_STEP,
    OP_FIRST,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_BEAT,
    COND_DISABLED,
    COND_TGT_ZERO,
    COND_CUR_ZERO,
    COND_NOT_ADJ,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic            accept;
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] jump;
  } ctl_t;

  typedef struct packed {
    logic enabled;
    logic tgt_zero;
    logic cur_zero;
    logic adj;
    logic out_free;
  } status_t;

  localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
  localparam logic [PC_W-1:0] STEP_GAIN   = 4'd1;
  localparam logic [PC_W-1:0] STEP_TARGET = 4'd2;
  localparam logic [PC_W-1:0] STEP_CHECK  = 4'd3;
  localparam logic [PC_W-1:0] STEP_MDEAD  = 4'd4;
  localparam logic [PC_W-1:0] STEP_CDEAD  = 4'd5;
  localparam logic [PC_W-1:0] STEP_MSET   = 4'd6;
  localparam logic [PC_W-1:0] STEP_HYST   = 4'd7;
  localparam logic [PC_W-1:0] STEP_TEST   = 4'd8;
  localparam logic [PC_W-1:0] STEP_MRATE  = 4'd9;
  localparam logic [PC_W-1:0] STEP_MOVE   = 4'd10;
  localparam logic [PC_W-1:0] STEP_FIRST  = 4'd11;
  localparam logic [PC_W-1:0] STEP_EMIT   = 4'd12;
  localparam logic [PC_W-1:0] STEP_RETRY  = 4'd13;

  // microcode: a jump is taken when its condition holds, else fall through
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '{accept: 1'b0, op: OP_NOP, cond: COND_ALWAYS, jump: STEP_WAIT};
    case (pc)
      STEP_WAIT:   c = '{1'b1, OP_LOAD,       COND_NO_BEAT,  STEP_WAIT};
      STEP_GAIN:   c = '{1'b0, OP_MUL_GAIN,   COND_DISABLED, STEP_WAIT};
      STEP_TARGET: c = '{1'b0, OP_TARGET,     COND_TGT_ZERO, STEP_WAIT};
      STEP_CHECK:  c = '{1'b0, OP_NOP,        COND_CUR_ZERO, STEP_FIRST};
      STEP_MDEAD:  c = '{1'b0, OP_MUL_DEAD,   COND_NEVER,    STEP_WAIT};
      STEP_CDEAD:  c = '{1'b0, OP_CMP_DEAD,   COND_NEVER,    STEP_WAIT};
      STEP_MSET:   c = '{1'b0, OP_MUL_SETTLE, COND_NEVER,    STEP_WAIT};
      STEP_HYST:   c = '{1'b0, OP_HYST,       COND_NEVER,    STEP_WAIT};
      STEP_TEST:   c = '{1'b0, OP_NOP,        COND_NOT_ADJ,  STEP_EMIT};
      STEP_MRATE:  c = '{1'b0, OP_MUL_RATE,   COND_NEVER,    STEP_WAIT};
      STEP_MOVE:   c = '{1'b0, OP_STEP,       COND_ALWAYS,   STEP_EMIT};
      STEP_FIRST:  c = '{1'b0, OP_FIRST,      COND_NEVER,    STEP_WAIT};
      STEP_EMIT:   c = '{1'b0, OP_EMIT,       COND_OUT_FREE, STEP_WAIT};
      STEP_RETRY:  c = '{1'b0, OP_NOP,        COND_ALWAYS,   STEP_EMIT};
      default:     c = '{1'b0, OP_NOP,        COND_ALWAYS,   STEP_WAIT};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/auto_framing_distance_control.sv */
`timescale 1ns / 1ps
`default_nettype none

// Auto framing distance control. Each input beat carries a frame's scene extents
// (min/max of x and y, Q16.16); the block scales the largest absolute extent by
// the framing gain into a target pullback distance and steps the camera distance
// toward it with a deadband/settle-band hysteresis, emitting one result beat per
// framed input (none when auto scale is off or the target is zero). Work runs as
// a microcode program over one shared 32x17 multiplier, one item at a time; the
// emit step waits until the output register can take the result. A finished
// result sits in the output register while the next beat is taken.
module auto_framing_distance_control (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [127:0] s_tdata,    // min_x, max_x, min_y, max_y
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [39:0]  m_tdata,    // camera_distance, adjusting, zero fill
  input  wire          cfg_wr_en,
  input  wire  [2:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);
  import afdc_pkg::*;

  cfg_t              cfg;
  ctl_t              ctl;
  status_t           stat;
  logic [DIST_W-1:0] camera_distance;
  logic              adjusting;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{enable:   1'b1,
               gain:     GAIN_RST,
               deadband: DEADBAND_RST,
               settle:   SETTLE_RST,
               zoom_out: ZOOM_OUT_RST,
               zoom_in:  ZOOM_IN_RST};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLE:   cfg.enable   <= cfg_data[0];
        REG_GAIN:     cfg.gain     <= cfg_data;
        REG_DEADBAND: cfg.deadband <= cfg_data;
        REG_SETTLE:   cfg.settle   <= cfg_data;
        REG_ZOOM_OUT: cfg.zoom_out <= cfg_data;
        REG_ZOOM_IN:  cfg.zoom_in  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  afdc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .ctl      (ctl)
  );

  afdc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .ctl             (ctl),
    .in_valid        (s_tvalid),
    .min_x           (s_tdata[31:0]),
    .max_x           (s_tdata[63:32]),
    .min_y           (s_tdata[95:64]),
    .max_y           (s_tdata[127:96]),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .camera_distance (camera_distance),
    .adjusting       (adjusting),
    .stat            (stat)
  );

  assign s_tready = ctl.accept;
  assign m_tdata  = {7'b0, adjusting, camera_distance};

  // a new result only comes from the emit step
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctl.op == OP_EMIT))
    else $error("result beat raised outside the emit step");

  // a framed distance is never zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:0] != '0))
    else $error("zero camera distance emitted");

  // an accepted beat always starts the program
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (ctl.op == OP_MUL_GAIN && !s_tready))
    else $error("sequencer did not advance after input beat");

endmodule

`default_nettype wire

/* rtl/afdc_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module afdc_seq (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  afdc_pkg::status_t stat,
  output afdc_pkg::ctl_t   ctl
);
  import afdc_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign ctl = ucode(pc);

  always_comb begin
    case (ctl.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_BEAT:  take = ~in_valid;
      COND_DISABLED: take = ~stat.enabled;
      COND_TGT_ZERO: take = stat.tgt_zero;
      COND_CUR_ZERO: take = stat.cur_zero;
      COND_NOT_ADJ:  take = ~stat.adj;
      COND_OUT_FREE: take = stat.out_free;
      default:       take = 1'b1;
    endcase
    pc_next = take ? ctl.jump : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/afdc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module afdc_datapath (
  input  wire                        clk,
  input  wire                        rst,
  input  afdc_pkg::cfg_t             cfg,
  input  afdc_pkg::ctl_t             ctl,
  input  wire                        in_valid,
  input  wire  signed [31:0]         min_x,
  input  wire  signed [31:0]         max_x,
  input  wire  signed [31:0]         min_y,
  input  wire  signed [31:0]         max_y,
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic [afdc_pkg::DIST_W-1:0] camera_distance,
  output logic                       adjusting,
  output afdc_pkg::status_t          stat
);
  import afdc_pkg::*;

  logic [DIST_W-1:0] ext;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] tgt;
  logic [DIST_W-1:0] diff;
  logic              up;
  logic [DIST_W-1:0] cur;
  logic              adj;
  logic              start;

  logic [DIST_W-1:0] ext_x;
  logic [DIST_W-1:0] ext_y;
  logic [DIST_W-1:0] mul_a;
  logic [MULB_W-1:0] mul_b;
  logic [PROD_W-1:0] product;
  logic [DIST_W-1:0] tgt_c;
  logic              up_c;
  logic [DIST_W-1:0] diff_c;
  logic [PROD_W-1:0] scaled_diff;
  logic [DIST_W-1:0] step_amt;
  logic              out_free;

  // |lo| reaches 2^31 for the most negative value, still fits 32 unsigned bits
  function automatic logic [DIST_W-1:0] axis_ext(input logic [31:0] lo, input logic [31:0] hi);
    logic [DIST_W-1:0] mag;
    mag = lo[31] ? (~lo + 32'd1) : lo;
    return (hi[31] || mag > hi) ? mag : hi;
  endfunction

  assign ext_x = axis_ext(min_x, max_x);
  assign ext_y = axis_ext(min_y, max_y);

  always_comb begin
    case (ctl.op)
      OP_MUL_GAIN: begin
        mul_a = ext;
        mul_b = {1'b0, cfg.gain};
      end
      OP_MUL_DEAD: begin
        mul_a = cur;
        mul_b = {1'b0, cfg.deadband} + MULB_W'(1);
      end
      OP_MUL_SETTLE: begin
        mul_a = cur;
        mul_b = {1'b0, cfg.settle};
      end
      OP_MUL_RATE: begin
        mul_a = diff;
        mul_b = up ? {1'b0, cfg.zoom_out} : {1'b0, cfg.zoom_in};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  // target = (extent * gain) >> 12, saturated to 32 bits
  assign tgt_c  = (|prod[PROD_W-1:DIST_W+12]) ? '1 : prod[DIST_W+11:12];
  assign up_c   = tgt_c > cur;
  assign diff_c = up_c ? tgt_c - cur : cur - tgt_c;

  // error compares without division: diff << 16 against band * cur
  assign scaled_diff = {1'b0, diff, 16'b0};
  assign step_amt    = prod[DIST_W+15:16];
  assign out_free    = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      adj       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (ctl.op)
        OP_HYST:  adj <= adj ? ~(scaled_diff < prod) : start;
        OP_STEP:  cur <= up ? cur + step_amt : cur - step_amt;
        OP_FIRST: cur <= tgt;
        default: begin
        end
      endcase
      if (ctl.op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD && in_valid) begin
      ext <= (ext_y > ext_x) ? ext_y : ext_x;
    end
    if (ctl.op == OP_MUL_GAIN || ctl.op == OP_MUL_DEAD ||
        ctl.op == OP_MUL_SETTLE || ctl.op == OP_MUL_RATE) begin
      prod <= product;
    end
    if (ctl.op == OP_TARGET) begin
      tgt  <= tgt_c;
      diff <= diff_c;
      up   <= up_c;
    end
    if (ctl.op == OP_CMP_DEAD) begin
      start <= scaled_diff >= prod;
    end
    if (ctl.op == OP_EMIT && out_free) begin
      camera_distance <= cur;
      adjusting       <= adj;
    end
  end

  assign stat = '{enabled:  cfg.enable,
                  tgt_zero: (tgt_c == '0),
                  cur_zero: (cur == '0),
                  adj:      adj,
                  out_free: out_free};

endmodule

`default_nettype wire
